// ===== hdl/bge_pkg.sv =====
// ---------------------------------------------------------------------------
// bge_pkg
// Shared types, constants and character decode for the bracket group
// extractor.
// ---------------------------------------------------------------------------
`default_nettype none

package bge_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int COORD_BITS  = 16;
   localparam int LEVEL_BITS  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);

   localparam logic [7:0] CHAR_PAREN_OPEN    = 8'h28;
   localparam logic [7:0] CHAR_BRACE_OPEN    = 8'h7B;
   localparam logic [7:0] CHAR_BRACKET_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_PAREN_CLOSE   = 8'h29;
   localparam logic [7:0] CHAR_BRACE_CLOSE   = 8'h7D;
   localparam logic [7:0] CHAR_BRACKET_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_SPACE         = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE       = 8'h0A;

   typedef enum logic [1:0] {
      KIND_PAREN   = 2'd0,
      KIND_BRACE   = 2'd1,
      KIND_BRACKET = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNMATCHED = 2'd1,
      ERR_OVERFLOW  = 2'd2
   } err_type;

   typedef struct packed {
      logic     hit;
      kind_type kind;
   } decode_type;

   typedef struct packed {
      logic        plane_valid;
      logic [7:0]  plane_char;
      logic        content_valid;
      logic [7:0]  content_char;
      logic        group_open;
      kind_type    group_kind;
      logic [15:0] group_row;
      logic [15:0] group_col;
      err_type     error_code;
   } rsp_type;

   function automatic decode_type decode_opener(input logic [7:0] c);
      decode_type d;
      d.hit  = 1'b1;
      d.kind = KIND_PAREN;
      case (c)
         CHAR_PAREN_OPEN:   d.kind = KIND_PAREN;
         CHAR_BRACE_OPEN:   d.kind = KIND_BRACE;
         CHAR_BRACKET_OPEN: d.kind = KIND_BRACKET;
         default:           d.hit  = 1'b0;
      endcase
      return d;
   endfunction

   function automatic decode_type decode_closer(input logic [7:0] c);
      decode_type d;
      d.hit  = 1'b1;
      d.kind = KIND_PAREN;
      case (c)
         CHAR_PAREN_CLOSE:   d.kind = KIND_PAREN;
         CHAR_BRACE_CLOSE:   d.kind = KIND_BRACE;
         CHAR_BRACKET_CLOSE: d.kind = KIND_BRACKET;
         default:            d.hit  = 1'b0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bge_ram.sv =====
// ---------------------------------------------------------------------------
// bge_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bge_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/bracket_group_extractor.sv =====
// ---------------------------------------------------------------------------
// bracket_group_extractor
// Tracks (), {} and [] nesting over a character stream and extracts the
// contents of each top-level group.
// ---------------------------------------------------------------------------
// One item is taken per clock cycle and its result appears in the cycle after;
// a new item is accepted in the same cycle the waiting result is taken, so
// throughput is one item per cycle whenever the result side keeps up, and
// the input stalls while a result is held back. The bracket kind
// stack lives in a RAM with registered read; the top entry is held in a
// register and the entry beneath it is read ahead every cycle, so a push or
// pop never waits on the RAM. The stack holds 32 levels; opening a 33rd
// level, or a closer that does not match, raises a sticky error and every
// later item returns only that error code until reset.
`default_nettype none

module bracket_group_extractor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // char_in
   input  wire logic        req_tuser,   // is_line_end
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // plane_char, content_char, group_row, group_col, error_code, zero pad
   output      logic [55:0] rsp_tdata,
   // plane_valid, content_valid, group_open, group_kind
   output      logic [4:0]  rsp_tuser
);

   import bge_pkg::*;

   logic [LEVEL_BITS-1:0] level_ff, level_in;
   kind_type              top_ff, top_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [COORD_BITS-1:0] col_ff, col_in;
   err_type               err_ff, err_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [1:0]            below_kind;
   logic [LEVEL_BITS-1:0] below_level;
   decode_type            op_dec, cl_dec;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign op_dec     = decode_opener(req_tdata);
   assign cl_dec     = decode_closer(req_tdata);

   // read ahead the entry under the new top
   assign below_level = level_in - LEVEL_BITS'(2);
   assign rd_addr     = below_level[ADDR_BITS-1:0];

   bge_ram #(
      .WIDTH (2),
      .DEPTH (STACK_DEPTH)
   ) u_kind_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (level_ff[ADDR_BITS-1:0]),
      .wr_data (op_dec.kind),
      .rd_addr (rd_addr),
      .rd_data (below_kind)
   );

   always_comb begin
      level_in = level_ff;
      top_in   = top_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      err_in   = err_ff;
      wr_en    = 1'b0;
      rsp_in   = '0;
      if (accept) begin
         if (err_ff != ERR_NONE) begin
            rsp_in.error_code = err_ff;
         end else if (req_tuser) begin
            if (level_ff != '0) begin
               rsp_in.content_valid = 1'b1;
               rsp_in.content_char  = CHAR_NEWLINE;
            end
            row_in = row_ff + COORD_BITS'(1);
            col_in = '0;
         end else if (op_dec.hit) begin
            if (level_ff == LEVEL_BITS'(STACK_DEPTH)) begin
               err_in            = ERR_OVERFLOW;
               rsp_in.error_code = ERR_OVERFLOW;
            end else begin
               if (level_ff == '0) begin
                  rsp_in.group_open = 1'b1;
                  rsp_in.group_kind = op_dec.kind;
                  rsp_in.group_row  = 16'(row_ff);
                  rsp_in.group_col  = 16'(col_ff);
               end else begin
                  rsp_in.content_valid = 1'b1;
                  rsp_in.content_char  = req_tdata;
               end
               wr_en              = 1'b1;
               top_in             = op_dec.kind;
               level_in           = level_ff + LEVEL_BITS'(1);
               rsp_in.plane_valid = 1'b1;
               rsp_in.plane_char  = CHAR_SPACE;
               col_in             = col_ff + COORD_BITS'(1);
            end
         end else if (cl_dec.hit) begin
            if (level_ff == '0 || top_ff != cl_dec.kind) begin
               err_in            = ERR_UNMATCHED;
               rsp_in.error_code = ERR_UNMATCHED;
            end else begin
               if (level_ff != LEVEL_BITS'(1)) begin
                  rsp_in.content_valid = 1'b1;
                  rsp_in.content_char  = req_tdata;
               end
               top_in             = kind_type'(below_kind);
               level_in           = level_ff - LEVEL_BITS'(1);
               rsp_in.plane_valid = 1'b1;
               rsp_in.plane_char  = CHAR_SPACE;
               col_in             = col_ff + COORD_BITS'(1);
            end
         end else begin
            rsp_in.plane_valid = 1'b1;
            if (level_ff == '0) begin
               rsp_in.plane_char = req_tdata;
            end else begin
               rsp_in.plane_char    = CHAR_SPACE;
               rsp_in.content_valid = 1'b1;
               rsp_in.content_char  = req_tdata;
            end
            col_in = col_ff + COORD_BITS'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.error_code, rsp_ff.group_col, rsp_ff.group_row,
                        rsp_ff.content_char, rsp_ff.plane_char};
   assign rsp_tuser  = {rsp_ff.group_kind, rsp_ff.group_open, rsp_ff.content_valid,
                        rsp_ff.plane_valid};

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_BITS'(STACK_DEPTH))
      else $error("stack level beyond depth");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff != ERR_NONE |=> err_ff == $past(err_ff))
      else $error("error state changed after being set");

   a_level_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(level_ff))
      else $error("stack level moved without a transfer");

   a_open_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.group_open |->
         !rsp_ff.content_valid && rsp_ff.error_code == ERR_NONE && rsp_ff.plane_valid)
      else $error("group open result carries content or error");

   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && err_ff != ERR_NONE |=> !rsp_ff.plane_valid && !rsp_ff.content_valid &&
         !rsp_ff.group_open && $stable(level_ff))
      else $error("item processed while in error");
`endif

endmodule

`default_nettype wire

// ===== dv/bracket_group_extractor_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bracket_group_extractor_tb
// Self-checking bench for the bracket group extractor. A scoreboard class
// tracks nesting, coordinates and the sticky error, predicts the one result
// of every accepted character or line-end transfer, and compares each result
// field by field. Stimulus is a short directed run, random well-nested text
// with deep dives to full stack depth, and one error at the very end with a
// few ignored items behind it.
// ---------------------------------------------------------------------------
module bracket_group_extractor_tb;

   import bge_pkg::*;

   class bracket_scoreboard;
      kind_type nest_kinds[STACK_DEPTH];
      int       nest_level;
      bit [15:0] row_pos;
      bit [15:0] col_pos;
      err_type  sticky_err;
      rsp_type  expected_rsps[$];
      int       mismatches;

      function new();
         nest_level = 0;
         row_pos    = '0;
         col_pos    = '0;
         sticky_err = ERR_NONE;
         mismatches = 0;
      endfunction

      static function int open_kind(bit [7:0] c);
         case (c)
            CHAR_PAREN_OPEN:   return int'(KIND_PAREN);
            CHAR_BRACE_OPEN:   return int'(KIND_BRACE);
            CHAR_BRACKET_OPEN: return int'(KIND_BRACKET);
            default:           return -1;
         endcase
      endfunction

      static function int close_kind(bit [7:0] c);
         case (c)
            CHAR_PAREN_CLOSE:   return int'(KIND_PAREN);
            CHAR_BRACE_CLOSE:   return int'(KIND_BRACE);
            CHAR_BRACKET_CLOSE: return int'(KIND_BRACKET);
            default:            return -1;
         endcase
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      function void note_transfer(bit line_end, bit [7:0] c);
         rsp_type e;
         int      ok;
         int      ck;
         bit      skip_content;
         bit      blank_close;
         e = '0;
         skip_content = 1'b0;
         blank_close  = 1'b0;
         ok = open_kind(c);
         ck = close_kind(c);
         if (sticky_err != ERR_NONE) begin
            e.error_code = sticky_err;
         end else if (line_end) begin
            if (nest_level != 0) begin
               e.content_valid = 1'b1;
               e.content_char  = CHAR_NEWLINE;
            end
            row_pos = row_pos + 16'd1;
            col_pos = '0;
         end else if (ok >= 0 && nest_level >= STACK_DEPTH) begin
            sticky_err   = ERR_OVERFLOW;
            e.error_code = sticky_err;
         end else if (ck >= 0 && (nest_level == 0 ||
                      nest_kinds[nest_level-1] != kind_type'(ck))) begin
            sticky_err   = ERR_UNMATCHED;
            e.error_code = sticky_err;
         end else begin
            if (ok >= 0) begin
               if (nest_level == 0) begin
                  e.group_open = 1'b1;
                  e.group_kind = kind_type'(ok);
                  e.group_row  = row_pos;
                  e.group_col  = col_pos;
                  skip_content = 1'b1;
               end
               nest_kinds[nest_level] = kind_type'(ok);
               nest_level++;
            end else if (ck >= 0) begin
               nest_level--;
               blank_close = 1'b1;
            end
            if (nest_level != 0 && !skip_content) begin
               e.content_valid = 1'b1;
               e.content_char  = c;
            end
            e.plane_valid = 1'b1;
            e.plane_char  = (nest_level == 0 && !blank_close) ? c : CHAR_SPACE;
            col_pos = col_pos + 16'd1;
         end
         expected_rsps = {expected_rsps, e};
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: result mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_transfer(logic [55:0] data, logic [4:0] user);
         rsp_type e;
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer %h/%h", data, user));
         end else begin
            e = expected_rsps.pop_front();
            check_field("plane_valid", 16'(user[0]), 16'(e.plane_valid));
            check_field("plane_char", 16'(data[7:0]), 16'(e.plane_char));
            check_field("content_valid", 16'(user[1]), 16'(e.content_valid));
            check_field("content_char", 16'(data[15:8]), 16'(e.content_char));
            check_field("group_open", 16'(user[2]), 16'(e.group_open));
            check_field("group_kind", 16'(user[4:3]), 16'(e.group_kind));
            check_field("group_row", data[31:16], e.group_row);
            check_field("group_col", data[47:32], e.group_col);
            check_field("error_code", 16'(data[49:48]), 16'(e.error_code));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // char_in
   logic        req_tuser = 1'b0; // is_line_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // plane_char, content_char, group_row, group_col, error_code, zero pad
   logic [55:0] rsp_tdata;
   // plane_valid, content_valid, group_open, group_kind
   logic [4:0]  rsp_tuser;

   bracket_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int dive_target   = 0;

   bracket_group_extractor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("bracket_group_extractor: mismatch");
      $finish;
   end

   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_transfer(rsp_tdata, rsp_tuser);
   end

   function automatic bit [7:0] opener_char(kind_type k);
      case (k)
         KIND_BRACE:   return CHAR_BRACE_OPEN;
         KIND_BRACKET: return CHAR_BRACKET_OPEN;
         default:      return CHAR_PAREN_OPEN;
      endcase
   endfunction

   function automatic bit [7:0] closer_char(kind_type k);
      case (k)
         KIND_BRACE:   return CHAR_BRACE_CLOSE;
         KIND_BRACKET: return CHAR_BRACKET_CLOSE;
         default:      return CHAR_PAREN_CLOSE;
      endcase
   endfunction

   function automatic bit [7:0] plain_char();
      bit [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (bracket_scoreboard::open_kind(c) >= 0 || bracket_scoreboard::close_kind(c) >= 0)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic bit [7:0] random_opener();
      return opener_char(kind_type'($urandom_range(0, 2)));
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input bit line_end, input bit [7:0] c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = line_end;
      req_tdata  = c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_transfer(line_end, c);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic close_all();
      while (sb.nest_level > 0)
         send_item(1'b0, closer_char(sb.nest_kinds[sb.nest_level-1]));
   endtask

   task automatic send_random_item();
      int roll;
      int lvl;
      roll = $urandom_range(0, 99);
      lvl  = sb.nest_level;
      if (lvl == 0 && dive_target == 0 && $urandom_range(0, 39) == 0)
         dive_target = STACK_DEPTH;
      if (dive_target != 0 && lvl >= dive_target)
         dive_target = 0;
      if (dive_target != 0 && roll < 60) begin
         send_item(1'b0, random_opener());
      end else if (roll < 8) begin
         send_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (roll < 26) begin
         if (lvl < STACK_DEPTH) send_item(1'b0, random_opener());
         else send_item(1'b0, closer_char(sb.nest_kinds[lvl-1]));
      end else if (roll < 46) begin
         if (lvl > 0) send_item(1'b0, closer_char(sb.nest_kinds[lvl-1]));
         else send_item(1'b0, random_opener());
      end else begin
         send_item(1'b0, plain_char());
      end
   endtask

   task automatic run_random(input int count);
      repeat (count) send_random_item();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed
      send_idle_pct = 10;
      recv_idle_pct = 73;
      send_item(1'b1, 8'hFF);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, CHAR_SPACE);
      send_item(1'b0, CHAR_PAREN_OPEN);
      send_item(1'b0, 8'h61);
      send_item(1'b1, 8'h00);
      send_item(1'b0, CHAR_BRACE_OPEN);
      send_item(1'b0, CHAR_BRACKET_OPEN);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, CHAR_BRACKET_CLOSE);
      send_item(1'b0, CHAR_BRACE_CLOSE);
      send_item(1'b0, CHAR_PAREN_CLOSE);
      send_item(1'b0, CHAR_BRACE_OPEN);
      send_item(1'b1, 8'h5A);
      send_item(1'b0, CHAR_BRACE_CLOSE);
      send_item(1'b0, CHAR_BRACKET_OPEN);
      send_item(1'b0, CHAR_PAREN_OPEN);
      send_item(1'b0, CHAR_PAREN_CLOSE);
      send_item(1'b0, CHAR_BRACKET_CLOSE);
      send_item(1'b1, 8'h00);

      // random phases
      run_random(510);
      wait_drained();
      send_idle_pct = 73;
      recv_idle_pct = 10;
      run_random(510);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(510);
      close_all();
      run_random(40);

      // one sticky error, then ignored items
      send_idle_pct = 10;
      recv_idle_pct = 73;
      case ($urandom_range(0, 2))
         0: begin
            close_all();
            send_item(1'b0, closer_char(kind_type'($urandom_range(0, 2))));
         end
         1: begin
            send_item(1'b0, CHAR_BRACE_OPEN);
            send_item(1'b0, CHAR_PAREN_CLOSE);
         end
         default: begin
            while (sb.nest_level < STACK_DEPTH) send_item(1'b0, random_opener());
            send_item(1'b0, random_opener());
         end
      endcase
      repeat (12) send_item(1'(($urandom_range(0, 3)) == 0), 8'($urandom_range(0, 255)));

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("bracket_group_extractor: match");
      end else begin
         $display("bracket_group_extractor: mismatch");
      end
      $finish;
   end

endmodule

// ===== bracket_group_extractor.f =====
hdl/bge_pkg.sv
hdl/bge_ram.sv
hdl/bracket_group_extractor.sv
dv/bracket_group_extractor_tb.sv
